// File: rtl/ttcs_pkg.sv
`default_nettype none

package ttcs_pkg;

    localparam int MAX_TITLE_DEF = 32;
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 6;
    localparam int CMP_W = 8;

    localparam logic [CFG_AW-1:0] REG_VIEW_MODE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_MAX_LENGTH = 1'b1;
    localparam logic [CFG_DW-1:0] MAX_LENGTH_RST = 6'd32;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] ROM_LO = 8'h90;
    localparam logic [7:0] ROM_HI = 8'hBF;
    localparam logic [7:0] SCORE_MAX = 8'hFF;
    localparam logic [7:0] SCORE_TOP2 = 8'd253;

    // machine character ROM, codes 0x90..0xBF
    localparam logic [7:0] ROM_MID [48] = '{
        8'h20, 8'h20, 8'h65, 8'h20, 8'h20, 8'h20, 8'h74, 8'h67,
        8'h68, 8'h20, 8'h62, 8'h78, 8'h64, 8'h72, 8'h70, 8'h63,
        8'h71, 8'h61, 8'h7A, 8'h77, 8'h73, 8'h75, 8'h69, 8'h20,
        8'h4F, 8'h6B, 8'h66, 8'h76, 8'h20, 8'h75, 8'h42, 8'h6A,
        8'h6E, 8'h20, 8'h55, 8'h6D, 8'h20, 8'h20, 8'h20, 8'h6F,
        8'h6C, 8'h41, 8'h6F, 8'h61, 8'h20, 8'h79, 8'h20, 8'h20
    };

    typedef struct packed {
        logic take;
        logic start;
        logic clean;
        logic emit;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clean_done;
        logic out_done;
    } dp_status_t;

    function automatic logic [7:0] rom_map(input logic [7:0] c);
        logic [7:0] off;
        off = c - ROM_LO;
        if (c == CH_NUL || c == CH_CR)
            return CH_NUL;
        else if (c >= 8'h20 && c <= 8'h5F)
            return c;
        else if (c >= ROM_LO && c <= ROM_HI)
            return ROM_MID[off[5:0]];
        else
            return CH_SPACE;
    endfunction

    function automatic logic is_alnum(input logic [7:0] v);
        return (v >= 8'h41 && v <= 8'h5A) || (v >= 8'h61 && v <= 8'h7A) ||
               (v >= 8'h30 && v <= 8'h39);
    endfunction

    function automatic logic is_safe(input logic [7:0] v, input logic disp);
        return is_alnum(v) || v == CH_SPACE || v == CH_DASH || v == CH_UNDER ||
               v == CH_LPAREN || v == CH_RPAREN || v == CH_DOT || v == CH_PLUS ||
               (disp && v == CH_SLASH);
    endfunction

    function automatic logic [7:0] add_score(input logic [7:0] s, input logic [7:0] v,
                                             input logic disp);
        logic [7:0] r;
        r = s;
        if (is_alnum(v))
            r = (s <= SCORE_TOP2) ? s + 8'd2 : SCORE_MAX;
        else if (is_safe(v, disp) && v != CH_SPACE && s != SCORE_MAX)
            r = s + 8'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ttcs_ram.sv
`default_nettype none

module ttcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/ttcs_ctrl.sv
`default_nettype none

module ttcs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire ttcs_pkg::dp_status_t status,
    output ttcs_pkg::ctrl_cmd_t      cmd
);

    import ttcs_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CLEAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;

    always_comb
    begin
        state_next  = state_reg;
        tready_next = tready_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.take  = tready_reg && in_valid;
                cmd.start = tready_reg && in_valid && in_last;
                if (cmd.start)
                begin
                    state_next  = ST_CLEAN;
                    tready_next = 1'b0;
                end
            end
            ST_CLEAN:
            begin
                cmd.clean = 1'b1;
                if (status.clean_done)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.out_done)
                begin
                    state_next  = ST_LOAD;
                    tready_next = 1'b1;
                end
            end
            default:
            begin
                state_next  = ST_LOAD;
                tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            tready_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

    assign in_ready = tready_reg;

endmodule

`default_nettype wire

// File: rtl/ttcs_datapath.sv
`default_nettype none

module ttcs_datapath #(
    parameter int MAX_TITLE = ttcs_pkg::MAX_TITLE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ttcs_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [ttcs_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic [7:0]                   in_byte,
    input  wire ttcs_pkg::ctrl_cmd_t          cmd,
    output ttcs_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [6:0]                        out_char,
    output logic                              out_present,
    output logic                              out_last,
    output logic                              out_title_valid
);

    import ttcs_pkg::*;

    localparam int CW = $clog2(MAX_TITLE + 1);
    localparam int AW = (MAX_TITLE > 1) ? $clog2(MAX_TITLE) : 1;

    logic              disp_mode_reg;
    logic [CFG_DW-1:0] max_len_reg;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          stop_seen_reg, stop_seen_next;
    logic [7:0]    ascii_score_reg, ascii_score_next;
    logic [7:0]    mapped_score_reg, mapped_score_next;
    logic          clean_disp_reg, clean_disp_next;

    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] ntrim_reg, ntrim_next;
    logic          prev_rep_reg, prev_rep_next;
    logic          alnum_reg, alnum_next;

    logic [CW-1:0] e_idx_reg, e_idx_next;
    logic          e_fly_reg, e_fly_next;
    logic          ovalid_reg, ovalid_next;
    logic [6:0]    ochar_reg, ochar_next;
    logic          opres_reg, opres_next;
    logic          olast_reg, olast_next;
    logic          otv_reg, otv_next;

    logic       store_ok, is_term, title_we;
    logic [7:0] title_rdata, v_sel;
    logic       direct, issue_rd, lead_skip, v_safe;
    logic       clean_we;
    logic [6:0] clean_wdata, clean_rdata;
    logic       free, issue_emit, emit_empty;

    assign store_ok = !stop_seen_reg &&
                      (CMP_W'(byte_count_reg) < CMP_W'(max_len_reg)) &&
                      (byte_count_reg < CW'(MAX_TITLE));
    assign is_term  = (in_byte == CH_NUL) || (in_byte == CH_CR);
    assign title_we = cmd.take && store_ok && !is_term;

    assign direct   = ascii_score_reg >= mapped_score_reg;
    assign v_sel    = direct ? title_rdata : rom_map(title_rdata);
    assign issue_rd = cmd.clean && (rd_idx_reg < byte_count_reg);
    assign lead_skip = (v_sel == CH_SPACE || v_sel == CH_DOT) && (n_reg == '0);
    assign v_safe   = is_safe(v_sel, clean_disp_reg);

    assign free       = !ovalid_reg || out_ready;
    assign issue_emit = cmd.emit && !e_fly_reg && free && (e_idx_reg < ntrim_reg);
    assign emit_empty = cmd.emit && !e_fly_reg && free && (ntrim_reg == '0) &&
                        (e_idx_reg == '0);

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        stop_seen_next    = stop_seen_reg;
        ascii_score_next  = ascii_score_reg;
        mapped_score_next = mapped_score_reg;
        clean_disp_next   = clean_disp_reg;
        rd_idx_next       = rd_idx_reg;
        rd_vld_next       = issue_rd;
        n_next            = n_reg;
        ntrim_next        = ntrim_reg;
        prev_rep_next     = prev_rep_reg;
        alnum_next        = alnum_reg;
        e_idx_next        = e_idx_reg;
        e_fly_next        = issue_emit;
        ovalid_next       = ovalid_reg;
        ochar_next        = ochar_reg;
        opres_next        = opres_reg;
        olast_next        = olast_reg;
        otv_next          = otv_reg;
        clean_we          = 1'b0;
        clean_wdata       = v_sel[6:0];

        // load
        if (cmd.take && store_ok)
        begin
            if (is_term)
            begin
                stop_seen_next = 1'b1;
            end
            else
            begin
                byte_count_next   = byte_count_reg + 1'b1;
                ascii_score_next  = add_score(ascii_score_reg, in_byte, disp_mode_reg);
                mapped_score_next = add_score(mapped_score_reg, rom_map(in_byte),
                                              disp_mode_reg);
            end
        end
        if (cmd.start)
        begin
            clean_disp_next = disp_mode_reg;
            rd_idx_next     = '0;
            n_next          = '0;
            ntrim_next      = '0;
            prev_rep_next   = 1'b0;
            alnum_next      = 1'b0;
            e_idx_next      = '0;
        end

        // clean pass, one stored byte per cycle
        if (issue_rd)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (rd_vld_reg && !lead_skip)
        begin
            if (!v_safe)
            begin
                if (!prev_rep_reg)
                begin
                    clean_we      = 1'b1;
                    clean_wdata   = CH_UNDER[6:0];
                    n_next        = n_reg + 1'b1;
                    ntrim_next    = n_reg + 1'b1;
                    prev_rep_next = 1'b1;
                end
            end
            else
            begin
                clean_we      = 1'b1;
                n_next        = n_reg + 1'b1;
                prev_rep_next = 1'b0;
                if (is_alnum(v_sel))
                begin
                    alnum_next = 1'b1;
                end
                if (v_sel != CH_SPACE && v_sel != CH_DOT)
                begin
                    ntrim_next = n_reg + 1'b1;
                end
            end
        end
        if (cmd.clear)
        begin
            byte_count_next   = '0;
            stop_seen_next    = 1'b0;
            ascii_score_next  = '0;
            mapped_score_next = '0;
        end

        // emit
        if (issue_emit)
        begin
            e_idx_next = e_idx_reg + 1'b1;
        end
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (e_fly_reg)
        begin
            ovalid_next = 1'b1;
            ochar_next  = clean_rdata;
            opres_next  = 1'b1;
            olast_next  = (e_idx_reg == ntrim_reg);
            otv_next    = alnum_reg;
        end
        else if (emit_empty)
        begin
            e_idx_next  = CW'(1);
            ovalid_next = 1'b1;
            ochar_next  = '0;
            opres_next  = 1'b0;
            olast_next  = 1'b1;
            otv_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_mode_reg    <= 1'b0;
            max_len_reg      <= MAX_LENGTH_RST;
            byte_count_reg   <= '0;
            stop_seen_reg    <= 1'b0;
            ascii_score_reg  <= '0;
            mapped_score_reg <= '0;
            clean_disp_reg   <= 1'b0;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            n_reg            <= '0;
            ntrim_reg        <= '0;
            prev_rep_reg     <= 1'b0;
            alnum_reg        <= 1'b0;
            e_idx_reg        <= '0;
            e_fly_reg        <= 1'b0;
            ovalid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_VIEW_MODE:  disp_mode_reg <= cfg_wdata[0];
                    REG_MAX_LENGTH: max_len_reg   <= cfg_wdata;
                    default:        ;
                endcase
            end
            byte_count_reg   <= byte_count_next;
            stop_seen_reg    <= stop_seen_next;
            ascii_score_reg  <= ascii_score_next;
            mapped_score_reg <= mapped_score_next;
            clean_disp_reg   <= clean_disp_next;
            rd_idx_reg       <= rd_idx_next;
            rd_vld_reg       <= rd_vld_next;
            n_reg            <= n_next;
            ntrim_reg        <= ntrim_next;
            prev_rep_reg     <= prev_rep_next;
            alnum_reg        <= alnum_next;
            e_idx_reg        <= e_idx_next;
            e_fly_reg        <= e_fly_next;
            ovalid_reg       <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        opres_reg <= opres_next;
        olast_reg <= olast_next;
        otv_reg   <= otv_next;
    end

    ttcs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TITLE),
        .AW    (AW)
    ) u_title_ram (
        .clk   (clk),
        .we    (title_we),
        .waddr (byte_count_reg[AW-1:0]),
        .wdata (in_byte),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (title_rdata)
    );

    ttcs_ram #(
        .WIDTH (7),
        .DEPTH (MAX_TITLE),
        .AW    (AW)
    ) u_clean_ram (
        .clk   (clk),
        .we    (clean_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (clean_wdata),
        .raddr (e_idx_reg[AW-1:0]),
        .rdata (clean_rdata)
    );

    assign status.clean_done = (rd_idx_reg == byte_count_reg) && !rd_vld_reg;
    assign status.out_done   = ovalid_reg && out_ready && olast_reg;

    assign out_valid       = ovalid_reg;
    assign out_char        = ochar_reg;
    assign out_present     = opres_reg;
    assign out_last        = olast_reg;
    assign out_title_valid = otv_reg;

endmodule

`default_nettype wire

// File: rtl/tape_title_charset_sanitizer.sv
// Channel  Dir  Signals                          Contents
// s_axis   in   tvalid tready tdata tlast        title_byte; tlast = last_byte
// m_axis   out  tvalid tready tdata tuser tlast  out_char; char_present, title_valid
// cfg      in   cfg_we cfg_addr cfg_wdata        0 view_mode, 1 max_length
//
// Title bytes are taken one per cycle while tready is high. After the last beat the stored
// title is cleaned at one byte per cycle through the title RAM read port, then
// emitted through the clean RAM read and the output register; a new character
// read is issued only when none is in flight and the output register is free.
// No input beat is taken from the last input beat until the last output beat.
// rst_n clears control state; the RAMs need no clearing.
`default_nettype none

module tape_title_charset_sanitizer #(
    parameter int MAX_TITLE = ttcs_pkg::MAX_TITLE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ttcs_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [ttcs_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] title_byte
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic [1:0]                        m_axis_tuser,   // [0] char_present, [1] title_valid
    output logic                              m_axis_tlast
);

    import ttcs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [6:0] out_char;
    logic       out_present;
    logic       out_title_valid;

    ttcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ttcs_datapath #(
        .MAX_TITLE (MAX_TITLE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_byte         (s_axis_tdata),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_char        (out_char),
        .out_present     (out_present),
        .out_last        (m_axis_tlast),
        .out_title_valid (out_title_valid)
    );

    assign m_axis_tdata = {1'b0, out_char};
    assign m_axis_tuser = {out_title_valid, out_present};

endmodule

`default_nettype wire

// File: tb/sv/tb_tape_title_charset_sanitizer.sv
module tb_tape_title_charset_sanitizer;
    import ttcs_pkg::*;

    localparam int TITLE_CAP = 32;
    localparam int SETTLE = 8;
    localparam int TAIL = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 410;

    // machine code 0x90..0xBF to ASCII
    localparam logic [7:0] GLYPH_TAB [48] = '{
        8'h20, 8'h20, 8'h65, 8'h20, 8'h20, 8'h20, 8'h74, 8'h67,
        8'h68, 8'h20, 8'h62, 8'h78, 8'h64, 8'h72, 8'h70, 8'h63,
        8'h71, 8'h61, 8'h7A, 8'h77, 8'h73, 8'h75, 8'h69, 8'h20,
        8'h4F, 8'h6B, 8'h66, 8'h76, 8'h20, 8'h75, 8'h42, 8'h6A,
        8'h6E, 8'h20, 8'h55, 8'h6D, 8'h20, 8'h20, 8'h20, 8'h6F,
        8'h6C, 8'h41, 8'h6F, 8'h61, 8'h20, 8'h79, 8'h20, 8'h20
    };

    typedef struct {
        logic [6:0] ch;
        logic       present;
        logic       last;
        logic       valid;
    } title_char_t;

    class title_scoreboard;
        logic             disp;
        logic [5:0]       max_len;
        logic [7:0]       raw [TITLE_CAP];
        int               n_raw;
        logic             stopped;
        logic [7:0]       ascii_pts;
        logic [7:0]       glyph_pts;
        title_char_t      expected_chars [$];
        int               errors;
        int               beats_in;
        int               beats_out;
        int               titles;

        function new();
            disp = 1'b0;
            max_len = MAX_LENGTH_RST;
            errors = 0;
            beats_in = 0;
            beats_out = 0;
            titles = 0;
            clear_load();
        endfunction

        function void clear_load();
            n_raw = 0;
            stopped = 1'b0;
            ascii_pts = 8'd0;
            glyph_pts = 8'd0;
        endfunction

        function logic [7:0] glyph_of(logic [7:0] c);
            if (c == CH_NUL || c == CH_CR)
                return CH_NUL;
            if (c >= 8'h20 && c <= 8'h5F)
                return c;
            if (c >= 8'h90 && c <= 8'hBF)
                return GLYPH_TAB[c - 8'h90];
            return CH_SPACE;
        endfunction

        function bit alnum_ch(logic [7:0] v);
            return (v >= "A" && v <= "Z") || (v >= "a" && v <= "z") ||
                   (v >= "0" && v <= "9");
        endfunction

        function bit safe_ch(logic [7:0] v, logic d);
            return alnum_ch(v) || v == CH_SPACE || v == CH_DASH || v == CH_UNDER ||
                   v == CH_LPAREN || v == CH_RPAREN || v == CH_DOT || v == CH_PLUS ||
                   (d && v == CH_SLASH);
        endfunction

        function logic [7:0] bump_score(logic [7:0] s, logic [7:0] v, logic d);
            if (alnum_ch(v))
                return (s <= 8'd253) ? s + 8'd2 : 8'hFF;
            if (safe_ch(v, d) && v != CH_SPACE && s != 8'hFF)
                return s + 8'd1;
            return s;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            if (idx == REG_VIEW_MODE)
                disp = val[0];
            else
                max_len = val;
        endfunction

        function void clean_title();
            logic [7:0]  v;
            logic [6:0]  chars [$];
            bit          direct;
            bit          rep;
            bit          seen_alnum;
            bit          ok;
            title_char_t e;
            direct = ascii_pts >= glyph_pts;
            rep = 0;
            seen_alnum = 0;
            for (int i = 0; i < n_raw; i++)
            begin
                v = direct ? raw[i] : glyph_of(raw[i]);
                if ((v == CH_SPACE || v == CH_DOT) && chars.size() == 0)
                    continue;
                if (!safe_ch(v, disp))
                begin
                    if (rep)
                        continue;
                    v = CH_UNDER;
                    rep = 1;
                end
                else
                    rep = 0;
                if (alnum_ch(v))
                    seen_alnum = 1;
                chars.push_back(v[6:0]);
            end
            while (chars.size() != 0 &&
                   (chars[$] == CH_SPACE[6:0] || chars[$] == CH_DOT[6:0]))
                void'(chars.pop_back());
            ok = seen_alnum && chars.size() != 0;
            if (chars.size() == 0)
            begin
                e.ch = 7'd0;
                e.present = 1'b0;
                e.last = 1'b1;
                e.valid = 1'b0;
                expected_chars.push_back(e);
            end
            else
            begin
                foreach (chars[i])
                begin
                    e.ch = chars[i];
                    e.present = 1'b1;
                    e.last = (i == chars.size() - 1);
                    e.valid = ok;
                    expected_chars.push_back(e);
                end
            end
            titles++;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int lim;
            beats_in++;
            lim = (max_len > TITLE_CAP) ? TITLE_CAP : max_len;
            if (!stopped && n_raw < lim)
            begin
                if (b == CH_NUL || b == CH_CR)
                    stopped = 1'b1;
                else
                begin
                    raw[n_raw] = b;
                    n_raw++;
                    ascii_pts = bump_score(ascii_pts, b, disp);
                    glyph_pts = bump_score(glyph_pts, glyph_of(b), disp);
                end
            end
            if (last)
            begin
                clean_title();
                clear_load();
            end
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_beat(logic [7:0] data, logic [1:0] user, logic last);
            title_char_t e;
            beats_out++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("beat %0d with nothing pending, tdata=%h", beats_out, data));
                return;
            end
            e = expected_chars.pop_front();
            if (data[6:0] !== e.ch)
                report($sformatf("beat %0d out_char %h want %h", beats_out, data[6:0], e.ch));
            if (data[7] !== 1'b0)
                report($sformatf("beat %0d tdata[7] not zero", beats_out));
            if (user[0] !== e.present)
                report($sformatf("beat %0d char_present %b want %b", beats_out, user[0],
                                 e.present));
            if (user[1] !== e.valid)
                report($sformatf("beat %0d title_valid %b want %b", beats_out, user[1],
                                 e.valid));
            if (last !== e.last)
                report($sformatf("beat %0d out_last %b want %b", beats_out, last, e.last));
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'd0;   // [7:0] title_byte
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;          // [6:0] out_char, [7] zero
    logic [1:0]          m_axis_tuser;          // [0] char_present, [1] title_valid
    logic                m_axis_tlast;

    title_scoreboard     sb;
    bit                  tx_idle = 1'b1;
    bit                  rx_idle = 1'b1;
    bit                  hold_req = 1'b0;
    int                  n_settings = 0;

    tape_title_charset_sanitizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function int draw_gap(bit on);
        return on ? $urandom_range(0, 12) : 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // receiver
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(rx_idle);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stalled for %0d cycles", STALL_LIMIT);
        $display("tb_tape_title_charset_sanitizer: FAIL");
        $finish;
    end

    task send_byte(logic [7:0] b, logic last);
        int gap;
        gap = draw_gap(tx_idle);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task quiesce(int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function logic [7:0] pick_byte(int kind);
        int r;
        if (kind == 2)
            return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'h20, 8'h5F))
                                               : 8'($urandom_range(8'h90, 8'hBF));
        if (kind == 3)
            return 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return 8'("A" + $urandom_range(0, 25));
            2, 3:    return 8'("a" + $urandom_range(0, 25));
            4:       return 8'("0" + $urandom_range(0, 9));
            5:       return CH_SPACE;
            6:       return CH_DOT;
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       return CH_DASH;
                    1:       return CH_UNDER;
                    2:       return CH_LPAREN;
                    3:       return CH_RPAREN;
                    4:       return CH_PLUS;
                    default: return CH_SLASH;
                endcase
            end
            8:       return 8'($urandom_range(8'h21, 8'h7E));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task send_title();
        int kind;
        int len;
        int stop_at;
        logic [7:0] b;
        kind = $urandom_range(0, 3);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 12);
        stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == stop_at)
                b = $urandom_range(0, 1) ? CH_NUL : CH_CR;
            else
                b = pick_byte(kind);
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        logic [CFG_DW-1:0] lim;
        logic [CFG_DW-1:0] dm;
        int phase;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        cfg_write(REG_VIEW_MODE, '0);
        cfg_write(REG_MAX_LENGTH, MAX_LENGTH_RST);
        n_settings++;
        send_byte(8'h41, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'h62, 1'b1);
        // leading blanks, unsafe byte, terminator, bytes after it, last on CR
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_DOT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(CH_CR, 1'b1);
        // cleans to nothing
        send_byte(CH_DOT, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        // machine code wins
        send_byte(8'h92, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'hA5, 1'b1);
        quiesce(SETTLE);
        // display mode flips inside a title
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'h41, 1'b0);
        quiesce(SETTLE);
        cfg_write(REG_VIEW_MODE, 6'd1);
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'h42, 1'b1);
        quiesce(SETTLE);
        cfg_write(REG_MAX_LENGTH, '0);
        n_settings++;
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);

        // random titles, one register setting per phase
        phase = 0;
        while (sb.beats_in < ITEM_TARGET)
        begin
            quiesce(SETTLE);
            case (phase)
                0:       lim = 6'd63;
                1:       lim = 6'd1;
                2:       lim = 6'd32;
                3:       lim = 6'd0;
                4:       lim = 6'd33;
                default:
                begin
                    case ($urandom_range(0, 7))
                        0:       lim = 6'd63;
                        1:       lim = 6'd32;
                        2:       lim = 6'd31;
                        3:       lim = 6'($urandom_range(0, 63));
                        default: lim = 6'($urandom_range(2, 16));
                    endcase
                end
            endcase
            dm = 6'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                dm[CFG_DW-1:1] = 5'($urandom_range(0, 31));
            cfg_write(REG_VIEW_MODE, dm);
            cfg_write(REG_MAX_LENGTH, lim);
            n_settings++;
            if (phase == 2)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
                hold_req = 1'b1;
            end
            else
            begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            repeat ($urandom_range(3, 6)) send_title();
            phase++;
        end

        quiesce(TAIL);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d titles, %0d input beats, %0d output beats, %0d settings",
                 sb.titles, sb.beats_in, sb.beats_out, n_settings);
        $display("incl. limits 0/1/32/33/63, terminators, long receiver hold-off");
        if (sb.errors == 0)
            $display("tb_tape_title_charset_sanitizer: PASS");
        else
            $display("tb_tape_title_charset_sanitizer: FAIL");
        $finish;
    end
endmodule

// File: sim.f
rtl/ttcs_pkg.sv
rtl/ttcs_ram.sv
rtl/ttcs_ctrl.sv
rtl/ttcs_datapath.sv
rtl/tape_title_charset_sanitizer.sv
tb/sv/tb_tape_title_charset_sanitizer.sv
